FILE: hdl/gelu_pkg.sv
// ----------------------------------------------------------------------------
// gelu_pkg
// Shared constants for the fixed-point GELU (tanh form) datapath: word
// widths, default formats and the Q30 coefficient set.
// ----------------------------------------------------------------------------
package gelu_pkg;

   localparam int IN_FRAC_BITS_DEF   = 16;
   localparam int WORK_FRAC_BITS_DEF = 30;

   // fixed port widths
   localparam int ACT_W = 27;
   localparam int OUT_W = 42;

   // all coefficients are held as Q30 and floored down to the working format
   localparam int C30_W = 31;

   localparam logic [C30_W-1:0] LOG2E_Q30   = 31'd1549082005;
   localparam logic [C30_W-1:0] SQRT2PI_Q30 = 31'd856722024;
   localparam logic [C30_W-1:0] CUBIC_Q30   = 31'd48012366;

   // (ln 2)^k / k! for k = 0..6
   localparam logic [C30_W-1:0] POLY_Q30 [7] = '{
      31'd1073741824, 31'd744261118, 31'd257941248, 31'd59597083,
      31'd10327387,   31'd1431680,   31'd165394
   };

   function automatic logic [C30_W-1:0] poly_coef(input int k, input int csh);
      return POLY_Q30[k] >> csh;
   endfunction

endpackage

FILE: hdl/gelu_tanh_fixed_point.sv
// Throughput is one word per cycle while the skid slot is empty; a full
// skid slot stalls the whole pipeline and raises req_stall.
// The depth is set by the divider, which resolves one quotient bit per stage,
// and by the six-stage Horner chain for 2^x.
// Reset clears the stage valid bits, the output valid flag and the skid flag;
// no data storage is cleared.
// ----------------------------------------------------------------------------
// gelu_tanh_fixed_point
// Pipelined GELU, tanh approximation, signed fixed point in and out. The
// input is clamped, widened, cubed and scaled; tanh comes from a 2^x
// polynomial and a pipelined restoring divider; a skid slot parts the
// pipeline from the result channel.
// ----------------------------------------------------------------------------
module gelu_tanh_fixed_point
   import gelu_pkg::*;
#(
   parameter int IN_FRAC_BITS   = IN_FRAC_BITS_DEF,
   parameter int WORK_FRAC_BITS = WORK_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [ACT_W-1:0] req_act_q16,
   input  logic                    req_last_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_gelu_q30,
   output logic                    rsp_last_out
);

   localparam int W   = WORK_FRAC_BITS;
   localparam int IB  = IN_FRAC_BITS;
   localparam int CSH = 30 - W;

   localparam int XW  = W + 11;   // clamped input in working format
   localparam int SW  = W + 4;    // input below saturation, |x| < 8
   localparam int X2W = W + 6;
   localparam int X3W = W + 10;
   localparam int IW  = W + 6;
   localparam int UW  = W + 6;
   localparam int AW  = W + 4;
   localparam int GW  = W + 6;
   localparam int SHW = W + 1;
   localparam int HW  = W + 2;
   localparam int EW  = W + 1;
   localparam int RW  = W + 2;
   localparam int QW  = W + 1;
   localparam int OW  = W + 2;
   localparam int CW  = (IB + 12 > ACT_W) ? IB + 12 : ACT_W;

   localparam int ST_X2 = 1;
   localparam int ST_X3 = 2;
   localparam int ST_IN = 3;
   localparam int ST_U  = 4;
   localparam int ST_G  = ST_U + 1;
   localparam int ST_E  = ST_G + 7;
   localparam int ST_D0 = ST_E + 1;
   localparam int ST_T  = ST_D0 + QW;
   localparam int ST_O  = ST_T + 1;
   localparam int NS    = ST_O + 1;

   localparam logic signed [CW-1:0] LIM_HI = CW'((longint'(1) <<< (IB + 10)) - 1);
   localparam logic signed [CW-1:0] LIM_LO = CW'(-(longint'(1) <<< (IB + 10)));
   localparam logic signed [XW-1:0] SAT_HI = XW'(longint'(1) <<< (W + 3));
   localparam logic signed [XW-1:0] SAT_LO = XW'(-(longint'(1) <<< (W + 3)));

   localparam logic [C30_W-1:0] LOG2E_K = LOG2E_Q30 >> CSH;
   localparam logic [C30_W-1:0] SQRT_K  = SQRT2PI_Q30 >> CSH;
   localparam logic [C30_W-1:0] CUBIC_K = CUBIC_Q30 >> CSH;

   localparam logic [SHW-1:0] ONE_S   = {1'b1, {W{1'b0}}};
   localparam logic [EW-1:0]  ONE_E   = {1'b1, {W{1'b0}}};
   localparam logic [RW-1:0]  ONE_R   = {2'b01, {W{1'b0}}};
   localparam logic [OW-1:0]  TWO_ONE = {2'b10, {W{1'b0}}};
   localparam logic [W-1:0]   FRAC_M  = {W{1'b1}};

   typedef struct packed {
      logic                 last;
      logic                 sat_pos;
      logic                 sat_neg;
      logic                 u_neg;
      logic signed [XW-1:0] x_full;
   } side_type;

   typedef struct packed {
      logic [SHW-1:0] s;
      logic [4:0]     n;
      logic           nbig;
      logic           rz;
   } expo_type;

   // pipeline control
   logic            adv;
   logic [NS-1:0]   valid_ff, valid_in;
   side_type        side_ff [NS];
   side_type        side_in [NS];

   // stage registers
   logic [X2W-1:0]        x2_ff, x2_in;
   logic signed [X3W-1:0] x3_ff, x3_in;
   logic signed [IW-1:0]  inner_ff, inner_in;
   logic signed [UW-1:0]  u_ff, u_in;
   expo_type              ex_ff [7];
   expo_type              ex_in;
   logic [HW-1:0]         acc_ff [6];
   logic [RW-1:0]         rem0_ff, rem0_in, den0_ff, den0_in;
   logic [RW-1:0]         div_rem_ff [QW];
   logic [RW-1:0]         div_den_ff [QW];
   logic [QW-1:0]         div_q_ff [QW];
   logic [OW-1:0]         onept_ff, onept_in;
   logic signed [OUT_W-1:0] g_ff, g_in;

   // output register and skid slot
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic signed [OUT_W-1:0] out_g_ff, skid_g_ff;
   logic                    out_last_ff, skid_last_ff;
   logic                    out_take, pipe_out, load_out, load_skid, out_from_skid;

   assign adv       = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign valid_in  = {valid_ff[NS-2:0], req_valid};

   // ---- clamp and widen
   logic signed [CW-1:0] act_ext, act_clamp;
   logic signed [XW-1:0] x_full_in;

   always_comb begin
      act_ext = CW'(req_act_q16);
      if (act_ext < LIM_LO) begin
         act_clamp = LIM_LO;
      end else if (act_ext > LIM_HI) begin
         act_clamp = LIM_HI;
      end else begin
         act_clamp = act_ext;
      end
      x_full_in = XW'(signed'(act_clamp[IB+10:0])) <<< (W - IB);
   end

   always_comb begin
      side_in[0].last    = req_last_in;
      side_in[0].sat_pos = (x_full_in >= SAT_HI);
      side_in[0].sat_neg = (x_full_in <= SAT_LO);
      side_in[0].u_neg   = 1'b0;
      side_in[0].x_full  = x_full_in;
      for (int i = 1; i < NS; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[ST_G].u_neg = u_ff[UW-1];
   end

   // ---- x^2, x^3, inner term, u
   logic signed [SW-1:0]          xs1, xs2, xs3;
   logic signed [2*SW-1:0]        sq_prod;
   logic signed [X2W+SW:0]        cube_prod;
   logic signed [C30_W+IW:0]      u_prod;
   logic signed [C30_W+X3W:0]     cub_prod;

   always_comb begin
      xs1       = signed'(side_ff[ST_X2-1].x_full[SW-1:0]);
      xs2       = signed'(side_ff[ST_X3-1].x_full[SW-1:0]);
      xs3       = signed'(side_ff[ST_IN-1].x_full[SW-1:0]);
      sq_prod   = xs1 * xs1;
      x2_in     = sq_prod[W +: X2W];
      cube_prod = signed'({1'b0, x2_ff}) * xs2;
      x3_in     = cube_prod[W +: X3W];
      cub_prod  = signed'({1'b0, CUBIC_K}) * x3_ff;
      inner_in  = IW'(xs3) + signed'(cub_prod[W +: IW]);
      u_prod    = signed'({1'b0, SQRT_K}) * inner_ff;
      u_in      = u_prod[W +: UW];
   end

   // ---- exponent: g = ceil(2|u| * log2(e)), split into shift and fraction
   logic [UW-1:0]          u_abs;
   logic [AW-1:0]          a_clip;
   logic [AW+C30_W:0]      exp_prod;
   logic [AW+C30_W+1:0]    exp_ceil;
   logic [GW-1:0]          gexp;

   always_comb begin
      u_abs = u_ff[UW-1] ? UW'(-u_ff) : UW'(u_ff);
      // beyond 16 the shift is past 32 either way
      a_clip   = (|u_abs[UW-1:AW]) ? {AW{1'b1}} : u_abs[AW-1:0];
      exp_prod = {a_clip, 1'b0} * LOG2E_K;
      exp_ceil = {1'b0, exp_prod} + (AW + C30_W + 2)'(FRAC_M);
      gexp     = exp_ceil[W +: GW];
      ex_in.s    = ONE_S - {1'b0, gexp[W-1:0]};
      ex_in.n    = gexp[W +: 5];
      ex_in.nbig = gexp[W+5];
      ex_in.rz   = (gexp[W-1:0] == '0);
   end

   // ---- 2^s by Horner, one coefficient per stage
   for (genvar k = 0; k < 6; k++) begin : g_horner
      localparam logic [HW-1:0] COEF = HW'(poly_coef(5 - k, CSH));
      logic [HW-1:0]     acc_prev;
      logic [HW+SHW-1:0] h_prod;
      logic [HW-1:0]     acc_in;

      if (k == 0) begin : g_first
         assign acc_prev = HW'(poly_coef(6, CSH));
      end else begin : g_rest
         assign acc_prev = acc_ff[k-1];
      end

      assign h_prod = acc_prev * ex_ff[k].s;
      assign acc_in = h_prod[W +: HW] + COEF;

      always_ff @(posedge clock) begin
         if (adv) begin
            acc_ff[k]  <= acc_in;
            ex_ff[k+1] <= ex_ff[k];
         end
      end
   end

   // ---- e = 2^-(n+1) * poly, a plain shift when the fraction is zero, or zero when nbig is set
   logic [EW-1:0] e_val;

   always_comb begin
      if (ex_ff[6].nbig) begin
         e_val = '0;
      end else if (ex_ff[6].rz) begin
         e_val = ONE_E >> ex_ff[6].n;
      end else begin
         e_val = EW'(acc_ff[5] >> ({1'b0, ex_ff[6].n} + 6'd1));
      end
      rem0_in = {1'b0, e_val};
      den0_in = ONE_R + {1'b0, e_val};
   end

   // ---- restoring divider: q = e * 2^(W+1) / (1 + e), one bit per stage
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [RW-1:0] rem_prev, den_prev;
      logic [QW-1:0] q_prev;
      logic [RW:0]   rem_sh;
      logic          take;
      logic [RW-1:0] rem_in;

      if (j == 0) begin : g_first
         assign rem_prev = rem0_ff;
         assign den_prev = den0_ff;
         assign q_prev   = '0;
      end else begin : g_rest
         assign rem_prev = div_rem_ff[j-1];
         assign den_prev = div_den_ff[j-1];
         assign q_prev   = div_q_ff[j-1];
      end

      assign rem_sh = {rem_prev, 1'b0};
      assign take   = (rem_sh >= {1'b0, den_prev});
      assign rem_in = take ? RW'(rem_sh - {1'b0, den_prev}) : RW'(rem_sh);

      always_ff @(posedge clock) begin
         if (adv) begin
            div_rem_ff[j] <= rem_in;
            div_den_ff[j] <= den_prev;
            div_q_ff[j]   <= {q_prev[QW-2:0], take};
         end
      end
   end

   // ---- 1 + tanh(u): q for negative u, 2 - q otherwise
   always_comb begin
      if (side_ff[ST_T-1].u_neg) begin
         onept_in = {1'b0, div_q_ff[QW-1]};
      end else begin
         onept_in = TWO_ONE - {1'b0, div_q_ff[QW-1]};
      end
   end

   // ---- (x/2) * (1 + tanh)
   logic signed [W+2:0]     xh;
   logic signed [2*W+5:0]   g_prod;

   always_comb begin
      xh     = signed'(side_ff[ST_O-1].x_full[SW-1:1]);
      g_prod = xh * signed'({1'b0, onept_ff});
      if (side_ff[ST_O-1].sat_pos) begin
         g_in = OUT_W'(signed'({side_ff[ST_O-1].x_full[XW-1:1], 1'b0}));
      end else if (side_ff[ST_O-1].sat_neg) begin
         g_in = '0;
      end else begin
         g_in = OUT_W'(signed'(g_prod[W +: W+6]));
      end
   end

   // ---- stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff  <= side_in;
         x2_ff    <= x2_in;
         x3_ff    <= x3_in;
         inner_ff <= inner_in;
         u_ff     <= u_in;
         ex_ff[0] <= ex_in;
         rem0_ff  <= rem0_in;
         den0_ff  <= den0_in;
         onept_ff <= onept_in;
         g_ff     <= g_in;
      end
   end

   // ---- output register with one skid slot
   assign out_take = rsp_valid_ff & ~rsp_stall;
   assign pipe_out = adv & valid_ff[ST_O];

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      out_from_skid = 1'b0;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_from_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_out) begin
         if (!rsp_valid_ff || out_take) begin
            load_out     = 1'b1;
            rsp_valid_in = 1'b1;
         end else begin
            load_skid     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_from_skid) begin
         out_g_ff    <= skid_g_ff;
         out_last_ff <= skid_last_ff;
      end else if (load_out) begin
         out_g_ff    <= g_ff;
         out_last_ff <= side_ff[ST_O].last;
      end
      if (load_skid) begin
         skid_g_ff    <= g_ff;
         skid_last_ff <= side_ff[ST_O].last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gelu_q30 = out_g_ff;
   assign rsp_last_out = out_last_ff;

endmodule
